// ===== rtl/core/rsi_pkg.sv =====
// Shared constants and types for the ray/sphere intersection core.
// No dependencies.
package rsi_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DIR_W       = 18;
  localparam int unsigned RAD_W       = 31;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned FRAC_BITS_D = 16;

  localparam int unsigned L_W    = COORD_W + 1;
  localparam int unsigned PROD_W = L_W + DIR_W;
  localparam int unsigned PROJ_W = PROD_W + 2;
  localparam int unsigned SQ_W   = 2 * L_W;
  localparam int unsigned LL_W   = SQ_W + 2;
  localparam int unsigned R2_W   = 2 * RAD_W;
  localparam int unsigned TLO_W  = LL_W / 2;
  localparam int unsigned ROOT_W = R2_W / 2;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(65536);
  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3
  } cfg_reg_t;

endpackage

// ===== rtl/core/rsi_geom.sv =====
// Geometry pipeline: L vector, projection tca, perpendicular distance and miss tests.
// Seven register stages; depends on rsi_pkg.
module rsi_geom
  import rsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_D,
  parameter int unsigned TCA_W     = PROJ_W - 2 - FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic signed [COORD_W-1:0] origin_z,
  input  logic signed [DIR_W-1:0]   dir_x,
  input  logic signed [DIR_W-1:0]   dir_y,
  input  logic signed [DIR_W-1:0]   dir_z,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  input  logic [RAD_W-1:0]          radius,
  output logic                      out_valid,
  output logic                      out_alive,
  output logic [TCA_W-1:0]          out_tca,
  output logic [R2_W-1:0]           out_h
);

  logic                     v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic signed [L_W-1:0]    lx1_r, ly1_r, lz1_r;
  logic signed [DIR_W-1:0]  dx1_r, dy1_r, dz1_r;
  logic [RAD_W-1:0]         rad1_r;
  logic signed [PROD_W-1:0] px2_r, py2_r, pz2_r;
  logic signed [SQ_W-1:0]   sx2_r, sy2_r, sz2_r;
  logic [R2_W-1:0]          r2_2_r, r2_3_r, r2_4_r, r2_5_r, r2_6_r;
  logic signed [PROJ_W-1:0] proj3_r;
  logic [LL_W-1:0]          ll3_r, ll4_r, ll5_r;
  logic                     alive4_r, alive5_r, alive6_r, alive7_r;
  logic [TCA_W-1:0]         tca4_r, tca5_r, tca6_r, tca7_r;
  logic                     big5_r;
  logic [LL_W-1:0]          tt5_r, d6_r;
  logic [R2_W-1:0]          h7_r;

  logic [63:0]              tca_ext;
  logic [TLO_W-1:0]         tca_lo;
  logic                     tca_big;
  logic                     alive7_nxt;

  assign tca_ext    = 64'(tca4_r);
  assign tca_lo     = tca_ext[TLO_W-1:0];
  assign tca_big    = |(tca_ext >> TLO_W);
  assign alive7_nxt = alive6_r && !(d6_r > LL_W'(r2_6_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    lx1_r  <= L_W'(center_x) - L_W'(origin_x);
    ly1_r  <= L_W'(center_y) - L_W'(origin_y);
    lz1_r  <= L_W'(center_z) - L_W'(origin_z);
    dx1_r  <= dir_x;
    dy1_r  <= dir_y;
    dz1_r  <= dir_z;
    rad1_r <= radius;

    px2_r  <= lx1_r * dx1_r;
    py2_r  <= ly1_r * dy1_r;
    pz2_r  <= lz1_r * dz1_r;
    sx2_r  <= lx1_r * lx1_r;
    sy2_r  <= ly1_r * ly1_r;
    sz2_r  <= lz1_r * lz1_r;
    r2_2_r <= R2_W'(rad1_r) * R2_W'(rad1_r);

    proj3_r <= PROJ_W'(px2_r) + PROJ_W'(py2_r) + PROJ_W'(pz2_r);
    ll3_r   <= LL_W'(unsigned'(sx2_r)) + LL_W'(unsigned'(sy2_r)) + LL_W'(unsigned'(sz2_r));
    r2_3_r  <= r2_2_r;

    alive4_r <= !proj3_r[PROJ_W-1];
    tca4_r   <= proj3_r[FRAC_BITS +: TCA_W];
    ll4_r    <= ll3_r;
    r2_4_r   <= r2_3_r;

    alive5_r <= alive4_r;
    tca5_r   <= tca4_r;
    big5_r   <= tca_big;
    tt5_r    <= LL_W'(tca_lo) * LL_W'(tca_lo);
    ll5_r    <= ll4_r;
    r2_5_r   <= r2_4_r;

    alive6_r <= alive5_r;
    tca6_r   <= tca5_r;
    d6_r     <= (big5_r || (tt5_r > ll5_r)) ? '0 : ll5_r - tt5_r;
    r2_6_r   <= r2_5_r;

    alive7_r <= alive7_nxt;
    tca7_r   <= tca6_r;
    h7_r     <= r2_6_r - d6_r[R2_W-1:0];
  end

  assign out_valid = v7_r;
  assign out_alive = alive7_r;
  assign out_tca   = tca7_r;
  assign out_h     = h7_r;

endmodule

// ===== rtl/core/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage, with side data.
// Depends on rsi_pkg.
module rsi_sqrt
  import rsi_pkg::*;
#(
  parameter int unsigned SIDE_W = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [R2_W-1:0]   in_h,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int unsigned REM_W = ROOT_W + 1;

  logic              v_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [R2_W-1:0]   h_r    [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [R2_W-1:0]   h_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign h_in    = in_h;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign h_in    = h_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign rem_sh = {rem_in, h_in[R2_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_r[i] <= {root_in[ROOT_W-2:0], ge};
      h_r[i]    <= h_in << 2;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((REM_W+1)'(rem_r[ROOT_W-1]) <= (REM_W+1)'({out_root, 1'b0})))
    else $error("sqrt remainder exceeds twice the root");
`endif

endmodule

// ===== rtl/core/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core, geometric method, signed fixed point.
// Depends on rsi_pkg, rsi_geom and rsi_sqrt.
//
// Usage:
//   Input: raise start with in_origin_* and in_dir_* for one cycle per ray; the item is
//   taken at every edge where start is high, busy is always low.
//   Output: out_valid pulses for one cycle with out_hit and out_hit_distance; the
//   receiver cannot stall, so results are never held back.
//   Config: cfg_we with cfg_index selects center x, y, z or radius; write only while idle.
// Timing:
//   A ray passes from the accepting edge through 7 geometry stages, 31 square root
//   stages (one root bit each) and an output register before out_valid rises.
//   Throughput is one ray per cycle; every stage advances each clock.
// Reset:
//   rst_n low clears all valid bits, dropping rays in flight; center resets to the
//   origin and radius to 1.0.
module ray_sphere_intersect_core
  import rsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_D
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [COORD_W-1:0] in_origin_z,
  input  logic signed [DIR_W-1:0]   in_dir_x,
  input  logic signed [DIR_W-1:0]   in_dir_y,
  input  logic signed [DIR_W-1:0]   in_dir_z,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [DIST_W-1:0]         out_hit_distance,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned TCA_W  = PROJ_W - 2 - FRAC_BITS;
  localparam int unsigned SIDE_W = TCA_W + 1;
  localparam int unsigned T_W    = ((TCA_W > DIST_W) ? TCA_W : DIST_W) + 1;

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [RAD_W-1:0]          radius_r;

  logic                      g_valid, g_alive;
  logic [TCA_W-1:0]          g_tca;
  logic [R2_W-1:0]           g_h;
  logic                      s_valid;
  logic [ROOT_W-1:0]         s_root;
  logic [SIDE_W-1:0]         s_side;
  logic                      s_alive;
  logic [TCA_W-1:0]          s_tca;

  logic [T_W-1:0]            tca_e, thc_e, t_sel;
  logic [DIST_W-1:0]         t_sat;

  logic                      out_valid_r, out_hit_r;
  logic [DIST_W-1:0]         out_hit_distance_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_CENTER_Z: center_z_r <= cfg_wdata;
        REG_RADIUS:   radius_r   <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_geom #(
    .FRAC_BITS(FRAC_BITS),
    .TCA_W    (TCA_W)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .radius   (radius_r),
    .out_valid(g_valid),
    .out_alive(g_alive),
    .out_tca  (g_tca),
    .out_h    (g_h)
  );

  rsi_sqrt #(
    .SIDE_W(SIDE_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (g_valid),
    .in_h     (g_h),
    .in_side  ({g_alive, g_tca}),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  assign s_alive = s_side[SIDE_W-1];
  assign s_tca   = s_side[TCA_W-1:0];
  assign tca_e   = T_W'(s_tca);
  assign thc_e   = T_W'(s_root);
  assign t_sel   = (tca_e >= thc_e) ? tca_e - thc_e : tca_e + thc_e;
  assign t_sat   = (|(t_sel >> DIST_W)) ? DIST_MAX : t_sel[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r          <= s_alive;
    out_hit_distance_r <= s_alive ? t_sat : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_hit_distance_r;

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == '0))
    else $error("miss item carries a nonzero distance");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("pipeline refused an item");
  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid && $past(rst_n)) |=> out_valid)
    else $error("root result lost at output register");
`endif

endmodule
